// ===== rtl/core/vces_pkg.sv =====
package vces_pkg;

  localparam int AMP_W    = 16;
  localparam int TIME_W   = 12;
  localparam int POS_W    = 4;
  localparam int VSUM_W   = 20;
  localparam int ESUM_W   = 22;
  localparam int VCNT_W   = 4;
  localparam int CCNT_W   = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Outer paddle that is left out of the outer layer entirely.
  localparam logic [3:0] OUTER_SKIP_COMPONENT = 4'd3;

  localparam logic [CFG_IDX_W-1:0] REG_AMP_THRESHOLD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VETO_SUM_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_LOW         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_HIGH        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_THRESHOLD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIMULATED_MODE   = 3'd5;

  localparam logic [AMP_W-1:0]  AMP_THRESHOLD_RST    = 16'd64;
  localparam logic [AMP_W-1:0]  VETO_SUM_LIMIT_RST   = 16'd128;
  localparam logic [TIME_W-1:0] TIME_LOW_RST         = 12'd50;
  localparam logic [TIME_W-1:0] TIME_HIGH_RST        = 12'd500;
  localparam logic [AMP_W-1:0]  ENERGY_THRESHOLD_RST = 16'd160;

  typedef struct packed {
    logic [AMP_W-1:0]  amp_threshold;
    logic [AMP_W-1:0]  veto_sum_limit;
    logic [TIME_W-1:0] time_low;
    logic [TIME_W-1:0] time_high;
    logic [AMP_W-1:0]  energy_threshold;
    logic              simulated_mode;
  } cfg_t;

  typedef struct packed {
    logic                    kind;
    logic                    layer;
    logic [3:0]              component;
    logic [AMP_W-1:0]        amplitude;
    logic [TIME_W-1:0]       hit_time;
    logic [AMP_W-1:0]        energy;
    logic                    sector;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } hit_t;

  typedef struct packed {
    logic [VSUM_W-1:0]       outer_amp_sum;
    logic [VSUM_W-1:0]       inner_amp_sum;
    logic [VCNT_W-1:0]       outer_count;
    logic [VCNT_W-1:0]       inner_count;
    logic                    veto_quiet;
    logic [ESUM_W-1:0]       energy_total;
    logic [ESUM_W-1:0]       energy_top;
    logic [ESUM_W-1:0]       energy_bottom;
    logic [AMP_W-1:0]        seed_energy;
    logic signed [POS_W-1:0] seed_x;
    logic signed [POS_W-1:0] seed_y;
    logic [CCNT_W-1:0]       crystal_count;
  } summary_t;

  function automatic logic [VSUM_W-1:0] sat_add_v(logic [VSUM_W-1:0] a, logic [AMP_W-1:0] v);
    logic [VSUM_W:0] s;
    s = {1'b0, a} + {{(VSUM_W-AMP_W+1){1'b0}}, v};
    return s[VSUM_W] ? {VSUM_W{1'b1}} : s[VSUM_W-1:0];
  endfunction

  function automatic logic [ESUM_W-1:0] sat_add_e(logic [ESUM_W-1:0] a, logic [AMP_W-1:0] v);
    logic [ESUM_W:0] s;
    s = {1'b0, a} + {{(ESUM_W-AMP_W+1){1'b0}}, v};
    return s[ESUM_W] ? {ESUM_W{1'b1}} : s[ESUM_W-1:0];
  endfunction

  function automatic logic [VCNT_W-1:0] sat_inc_v(logic [VCNT_W-1:0] a);
    return (a == {VCNT_W{1'b1}}) ? a : a + VCNT_W'(1);
  endfunction

  function automatic logic [CCNT_W-1:0] sat_inc_c(logic [CCNT_W-1:0] a);
    return (a == {CCNT_W{1'b1}}) ? a : a + CCNT_W'(1);
  endfunction

endpackage

// ===== rtl/core/vces_accum.sv =====
module vces_accum (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              step_last,
  input  vces_pkg::hit_t    hit,
  input  vces_pkg::cfg_t    cfg,
  output vces_pkg::summary_t summary
);
  import vces_pkg::*;

  logic [VSUM_W-1:0]       outer_acc, outer_acc_next;
  logic [VSUM_W-1:0]       inner_acc, inner_acc_next;
  logic [VCNT_W-1:0]       outer_hits, outer_hits_next;
  logic [VCNT_W-1:0]       inner_hits, inner_hits_next;
  logic [ESUM_W-1:0]       total_acc, total_acc_next;
  logic [ESUM_W-1:0]       top_acc, top_acc_next;
  logic [ESUM_W-1:0]       bottom_acc, bottom_acc_next;
  logic [AMP_W-1:0]        best_energy, best_energy_next;
  logic signed [POS_W-1:0] best_x, best_x_next;
  logic signed [POS_W-1:0] best_y, best_y_next;
  logic [CCNT_W-1:0]       used_crystals, used_crystals_next;

  logic in_window, counts, outer_sel, inner_sel, crystal_used;

  always_comb begin
    in_window = cfg.simulated_mode ||
                (hit.hit_time > cfg.time_low && hit.hit_time < cfg.time_high);
    counts       = (hit.amplitude > cfg.amp_threshold) && in_window;
    outer_sel    = !hit.kind && !hit.layer && (hit.component != OUTER_SKIP_COMPONENT);
    inner_sel    = !hit.kind && hit.layer;
    crystal_used = hit.kind && (hit.energy > cfg.energy_threshold);

    outer_acc_next     = outer_sel ? sat_add_v(outer_acc, hit.amplitude) : outer_acc;
    inner_acc_next     = inner_sel ? sat_add_v(inner_acc, hit.amplitude) : inner_acc;
    outer_hits_next    = (outer_sel && counts) ? sat_inc_v(outer_hits) : outer_hits;
    inner_hits_next    = (inner_sel && counts) ? sat_inc_v(inner_hits) : inner_hits;
    used_crystals_next = crystal_used ? sat_inc_c(used_crystals) : used_crystals;
    total_acc_next     = crystal_used ? sat_add_e(total_acc, hit.energy) : total_acc;
    top_acc_next       = (crystal_used && !hit.sector) ? sat_add_e(top_acc, hit.energy)
                                                      : top_acc;
    bottom_acc_next    = (crystal_used && hit.sector) ? sat_add_e(bottom_acc, hit.energy)
                                                     : bottom_acc;
    // A tie keeps the earlier seed.
    if (crystal_used && hit.energy > best_energy) begin
      best_energy_next = hit.energy;
      best_x_next      = hit.pos_x;
      best_y_next      = hit.pos_y;
    end else begin
      best_energy_next = best_energy;
      best_x_next      = best_x;
      best_y_next      = best_y;
    end

    summary.outer_amp_sum = outer_acc_next;
    summary.inner_amp_sum = inner_acc_next;
    summary.outer_count   = outer_hits_next;
    summary.inner_count   = inner_hits_next;
    summary.veto_quiet    = (outer_hits_next == '0) && (inner_hits_next == '0) &&
                            (outer_acc_next <= VSUM_W'(cfg.veto_sum_limit)) &&
                            (inner_acc_next <= VSUM_W'(cfg.veto_sum_limit));
    summary.energy_total  = total_acc_next;
    summary.energy_top    = top_acc_next;
    summary.energy_bottom = bottom_acc_next;
    summary.seed_energy   = best_energy_next;
    summary.seed_x        = best_x_next;
    summary.seed_y        = best_y_next;
    summary.crystal_count = used_crystals_next;
  end

  // The last word of an event leaves the accumulators cleared for the next one.
  always_ff @(posedge clk) begin
    if (rst || (step && step_last)) begin
      outer_acc     <= '0;
      inner_acc     <= '0;
      outer_hits    <= '0;
      inner_hits    <= '0;
      total_acc     <= '0;
      top_acc       <= '0;
      bottom_acc    <= '0;
      best_energy   <= '0;
      best_x        <= '0;
      best_y        <= '0;
      used_crystals <= '0;
    end else if (step) begin
      outer_acc     <= outer_acc_next;
      inner_acc     <= inner_acc_next;
      outer_hits    <= outer_hits_next;
      inner_hits    <= inner_hits_next;
      total_acc     <= total_acc_next;
      top_acc       <= top_acc_next;
      bottom_acc    <= bottom_acc_next;
      best_energy   <= best_energy_next;
      best_x        <= best_x_next;
      best_y        <= best_y_next;
      used_crystals <= used_crystals_next;
    end
  end

endmodule

// ===== rtl/core/veto_calorimeter_event_summarizer.sv =====
// Veto and calorimeter event summariser. One hit word is accepted per clock cycle
// and each word is first captured in the input register at the accepting edge; a word
// not marked last is folded into the running event sums at the next edge. The word
// marked last is folded in, and loads the summary into the output register, at the
// first edge at which the output register is free. Hits keep flowing while a summary
// waits to be taken; only a last word that finds the output register still full waits
// in the input register, and then input ready drops until the summary is read.
// Thresholds and the time window are to be set through the write port only while no
// event is in progress; the block itself does not enforce this.
module veto_calorimeter_event_summarizer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [vces_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vces_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                kind,
  input  logic                                layer,
  input  logic [3:0]                          component,
  input  logic [vces_pkg::AMP_W-1:0]          amplitude,
  input  logic [vces_pkg::TIME_W-1:0]         hit_time,
  input  logic [vces_pkg::AMP_W-1:0]          energy,
  input  logic                                sector,
  input  logic signed [vces_pkg::POS_W-1:0]   pos_x,
  input  logic signed [vces_pkg::POS_W-1:0]   pos_y,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [vces_pkg::VSUM_W-1:0]         outer_amp_sum,
  output logic [vces_pkg::VSUM_W-1:0]         inner_amp_sum,
  output logic [vces_pkg::VCNT_W-1:0]         outer_count,
  output logic [vces_pkg::VCNT_W-1:0]         inner_count,
  output logic                                veto_quiet,
  output logic [vces_pkg::ESUM_W-1:0]         energy_total,
  output logic [vces_pkg::ESUM_W-1:0]         energy_top,
  output logic [vces_pkg::ESUM_W-1:0]         energy_bottom,
  output logic [vces_pkg::AMP_W-1:0]          seed_energy,
  output logic signed [vces_pkg::POS_W-1:0]   seed_x,
  output logic signed [vces_pkg::POS_W-1:0]   seed_y,
  output logic [vces_pkg::CCNT_W-1:0]         crystal_count
);
  import vces_pkg::*;

  cfg_t     cfg;
  hit_t     hit;
  logic     hit_valid;
  logic     hit_last;
  summary_t summary;
  summary_t result;
  logic     out_free;
  logic     step;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.amp_threshold    <= AMP_THRESHOLD_RST;
      cfg.veto_sum_limit   <= VETO_SUM_LIMIT_RST;
      cfg.time_low         <= TIME_LOW_RST;
      cfg.time_high        <= TIME_HIGH_RST;
      cfg.energy_threshold <= ENERGY_THRESHOLD_RST;
      cfg.simulated_mode   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AMP_THRESHOLD:    cfg.amp_threshold    <= cfg_data;
        REG_VETO_SUM_LIMIT:   cfg.veto_sum_limit   <= cfg_data;
        REG_TIME_LOW:         cfg.time_low         <= cfg_data[TIME_W-1:0];
        REG_TIME_HIGH:        cfg.time_high        <= cfg_data[TIME_W-1:0];
        REG_ENERGY_THRESHOLD: cfg.energy_threshold <= cfg_data;
        REG_SIMULATED_MODE:   cfg.simulated_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid || out_ready;
  assign step     = hit_valid && (!hit_last || out_free);
  assign in_ready = !hit_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid <= 1'b0;
    end else if (in_ready) begin
      hit_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hit.kind      <= kind;
      hit.layer     <= layer;
      hit.component <= component;
      hit.amplitude <= amplitude;
      hit.hit_time  <= hit_time;
      hit.energy    <= energy;
      hit.sector    <= sector;
      hit.pos_x     <= pos_x;
      hit.pos_y     <= pos_y;
      hit_last      <= last;
    end
  end

  vces_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .step_last (hit_last),
    .hit       (hit),
    .cfg       (cfg),
    .summary   (summary)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && hit_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && hit_last) begin
      result <= summary;
    end
  end

  assign outer_amp_sum = result.outer_amp_sum;
  assign inner_amp_sum = result.inner_amp_sum;
  assign outer_count   = result.outer_count;
  assign inner_count   = result.inner_count;
  assign veto_quiet    = result.veto_quiet;
  assign energy_total  = result.energy_total;
  assign energy_top    = result.energy_top;
  assign energy_bottom = result.energy_bottom;
  assign seed_energy   = result.seed_energy;
  assign seed_x        = result.seed_x;
  assign seed_y        = result.seed_y;
  assign crystal_count = result.crystal_count;

  // Only a last word facing an unread summary may be held back.
  a_hold_only_on_full_output: assert property (@(posedge clk) disable iff (rst)
    (hit_valid && !step) |-> (hit_last && out_valid && !out_ready))
    else $error("input register held without a waiting summary");

  // A new summary never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (step && hit_last) |-> (!out_valid || out_ready))
    else $error("summary overwritten before it was read");

  a_quiet_needs_no_counts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && veto_quiet) |-> (outer_count == '0 && inner_count == '0))
    else $error("quiet flag with counted veto hits");

  // Any used crystal has a nonzero energy, so a seed exists exactly when one was used.
  a_seed_matches_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((crystal_count == '0) == (seed_energy == '0)))
    else $error("seed energy disagrees with crystal count");

endmodule
